// ----- rtl/xypl_pkg.sv -----
// Package for the X/Y position line parser.
// Holds the parse phase codes, character constants and the line result type.
// No dependencies.
package xypl_pkg;

   localparam int PHASE_W = 4;

   localparam logic [PHASE_W-1:0] PH_X     = 4'd0;
   localparam logic [PHASE_W-1:0] PH_C1    = 4'd1;
   localparam logic [PHASE_W-1:0] PH_XPRE  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_XSGN  = 4'd3;
   localparam logic [PHASE_W-1:0] PH_XDIG  = 4'd4;
   localparam logic [PHASE_W-1:0] PH_Y     = 4'd5;
   localparam logic [PHASE_W-1:0] PH_C2    = 4'd6;
   localparam logic [PHASE_W-1:0] PH_YPRE  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_YSGN  = 4'd8;
   localparam logic [PHASE_W-1:0] PH_YDIG  = 4'd9;
   localparam logic [PHASE_W-1:0] PH_MATCH = 4'd10;
   localparam logic [PHASE_W-1:0] PH_FAIL  = 4'd11;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_X     = 8'h58;
   localparam logic [7:0] CH_Y     = 8'h59;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

   // Outcome of a line at its LF, as seen by the holding logic.
   typedef struct packed {
      logic        matched;
      logic [15:0] x_val;
      logic [15:0] y_val;
   } line_result_type;

endpackage

// ----- rtl/xypl_line_parse.sv -----
// Character-level parser for "X:<int>,Y:<int>" lines.
// Keeps the parse phase, sign, accumulators and line length; reports each line's outcome.
// Depends on xypl_pkg.
module xypl_line_parse #(
   parameter int LINE_CHARS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     char_en,
   input  logic [7:0]               char_in,
   output xypl_pkg::line_result_type line_out
);
   import xypl_pkg::*;

   localparam int CNT_W = $clog2(LINE_CHARS - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_CHARS - 2);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [15:0]        x_acc_ff, x_acc_in;
   logic [15:0]        y_acc_ff, y_acc_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic        is_digit, is_blank, is_sign;
   logic [15:0] digit_val;
   logic [15:0] x_times10, y_times10;
   logic [15:0] y_signed;

   assign is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
   assign is_blank  = (char_in == CH_SPACE) || (char_in == CH_TAB) ||
                      (char_in == CH_VT) || (char_in == CH_FF);
   assign is_sign   = (char_in == CH_PLUS) || (char_in == CH_MINUS);
   assign digit_val = {12'd0, char_in[3:0]};
   assign x_times10 = (x_acc_ff << 3) + (x_acc_ff << 1);
   assign y_times10 = (y_acc_ff << 3) + (y_acc_ff << 1);
   assign y_signed  = neg_ff ? (16'd0 - y_acc_ff) : y_acc_ff;

   // A line that ends while the Y digits are still running counts as complete.
   always_comb begin
      line_out.matched = (phase_ff == PH_MATCH) || (phase_ff == PH_YDIG);
      line_out.x_val   = x_acc_ff;
      line_out.y_val   = (phase_ff == PH_YDIG) ? y_signed : y_acc_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      x_acc_in = x_acc_ff;
      y_acc_in = y_acc_ff;
      count_in = count_ff;
      if (char_en) begin
         if (char_in == CH_CR) begin
            // Carriage returns are dropped entirely.
         end else if (char_in == CH_LF) begin
            phase_in = PH_X;
            neg_in   = 1'b0;
            x_acc_in = '0;
            y_acc_in = '0;
            count_in = '0;
         end else if (count_ff < CNT_LIMIT) begin
            count_in = count_ff + 1'b1;
            unique case (phase_ff)
               PH_X:  phase_in = (char_in == CH_X) ? PH_C1 : PH_FAIL;
               PH_C1: phase_in = (char_in == CH_COLON) ? PH_XPRE : PH_FAIL;
               PH_XPRE, PH_XSGN: begin
                  if (phase_ff == PH_XPRE && is_blank) begin
                  end else if (phase_ff == PH_XPRE && is_sign) begin
                     neg_in   = (char_in == CH_MINUS);
                     phase_in = PH_XSGN;
                  end else if (is_digit) begin
                     x_acc_in = digit_val;
                     phase_in = PH_XDIG;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_XDIG: begin
                  if (is_digit) begin
                     x_acc_in = x_times10 + digit_val;
                  end else if (char_in == CH_COMMA) begin
                     x_acc_in = neg_ff ? (16'd0 - x_acc_ff) : x_acc_ff;
                     neg_in   = 1'b0;
                     phase_in = PH_Y;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_Y:  phase_in = (char_in == CH_Y) ? PH_C2 : PH_FAIL;
               PH_C2: phase_in = (char_in == CH_COLON) ? PH_YPRE : PH_FAIL;
               PH_YPRE, PH_YSGN: begin
                  if (phase_ff == PH_YPRE && is_blank) begin
                  end else if (phase_ff == PH_YPRE && is_sign) begin
                     neg_in   = (char_in == CH_MINUS);
                     phase_in = PH_YSGN;
                  end else if (is_digit) begin
                     y_acc_in = digit_val;
                     phase_in = PH_YDIG;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_YDIG: begin
                  if (is_digit) begin
                     y_acc_in = y_times10 + digit_val;
                  end else begin
                     y_acc_in = y_signed;
                     neg_in   = 1'b0;
                     phase_in = PH_MATCH;
                  end
               end
               PH_MATCH: phase_in = PH_MATCH;
               default:  phase_in = PH_FAIL;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_X;
         neg_ff   <= 1'b0;
         x_acc_ff <= '0;
         y_acc_ff <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         x_acc_ff <= x_acc_in;
         y_acc_ff <= y_acc_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/xy_position_line_parser.sv -----
// X/Y position line parser: input register, per-item update, result register.
// Holds the timeout register, held position and elapsed-time counter.
// Depends on xypl_pkg and xypl_line_parse.
//
// Usage: each request on the req_ channel is either a received character
// (req_tuser = 0, req_tdata = byte) or a one-millisecond tick (req_tuser = 1).
// Every request produces exactly one response on the rsp_ channel carrying the
// held X and Y after that request, an updated flag for an LF that ended a
// valid "X:<int>,Y:<int>" line, and a timed_out flag while the elapsed time
// exceeds the timeout (the position then reads as zero).
// Each request is held in the input register and its response in the response
// register; the parse state is updated between the two registers.
// One request is accepted per cycle while the receiver does not stall.
// When the receiver stalls, the response register and then the input register
// fill, after which req_tready drops; nothing is lost.
// csr_ writes set timeout_ms and are always accepted; write only while idle.
// Synchronous reset clears the parse state, held position and elapsed time
// and loads a timeout of 500 ms.
module xy_position_line_parser #(
   parameter int LINE_CHARS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] x_pos, [31:16] y_pos
   output logic [1:0]  rsp_tuser,   // [0] updated, [1] timed_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import xypl_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic        in_func_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff;
   logic [1:0]  out_user_ff;
   logic [15:0] timeout_ff;
   logic signed [15:0] x_held_ff, x_held_in;
   logic signed [15:0] y_held_ff, y_held_in;
   logic [15:0] elapsed_ff, elapsed_in;

   logic            out_free, advance, is_lf, updated, timed;
   line_result_type line_res;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign advance     = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   assign csr_ready   = 1'b1;

   xypl_line_parse #(
      .LINE_CHARS(LINE_CHARS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .char_en (advance && !in_func_ff),
      .char_in (in_byte_ff),
      .line_out(line_res)
   );

   assign is_lf   = !in_func_ff && (in_byte_ff == CH_LF);
   assign updated = is_lf && line_res.matched;

   always_comb begin
      elapsed_in = elapsed_ff;
      if (updated) begin
         elapsed_in = '0;
      end else if (in_func_ff && elapsed_ff != ELAPSED_MAX) begin
         elapsed_in = elapsed_ff + 16'd1;
      end
      timed     = elapsed_in > timeout_ff;
      x_held_in = updated ? line_res.x_val : x_held_ff;
      y_held_in = updated ? line_res.y_val : y_held_ff;
      if (timed) begin
         x_held_in = '0;
         y_held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         x_held_ff    <= '0;
         y_held_ff    <= '0;
         elapsed_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
         if (advance) begin
            x_held_ff  <= x_held_in;
            y_held_ff  <= y_held_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= {y_held_in, x_held_in};
         out_user_ff <= {timed, updated};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ----- test/xy_position_line_parser_checker.sv -----
`timescale 1ns / 100ps
// Checker for the X/Y position line parser: predicts one response per request.
// Watches the req_, rsp_ and csr_ channels and compares each response field.
// Depends on xypl_pkg for the phase codes and character constants.
module xy_position_line_parser_checker #(
   parameter int LINE_CHARS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);
   import xypl_pkg::*;

   typedef struct packed {
      logic [15:0] x_pos;
      logic [15:0] y_pos;
      logic        updated;
      logic        timed_out;
   } position_type;

   position_type expected_positions[$];

   logic [15:0]        timeout_ms;
   logic [PHASE_W-1:0] phase;
   logic               sign_neg;
   logic [15:0]        x_accum;
   logic [15:0]        y_accum;
   logic [7:0]         line_count;
   logic [15:0]        x_held;
   logic [15:0]        y_held;
   logic [15:0]        elapsed_ms;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
   endfunction

   function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] c);
      return 16'(acc * 16'd10 + 16'(c - CH_ZERO));
   endfunction

   // The sign belongs to the number just finished, so it is dropped once applied.
   function automatic logic [15:0] signed_value(input logic [15:0] v);
      logic [15:0] r;
      r = sign_neg ? 16'(16'd0 - v) : v;
      sign_neg = 1'b0;
      return r;
   endfunction

   task automatic clear_line();
      phase      = PH_X;
      sign_neg   = 1'b0;
      x_accum    = '0;
      y_accum    = '0;
      line_count = '0;
   endtask

   // Blanks and a sign are only allowed while still in the leading part.
   task automatic start_number(input logic [7:0] c, input logic [PHASE_W-1:0] pre,
                               inout logic [15:0] acc);
      if (phase == pre && is_blank(c)) begin
         phase = pre;
      end else if (phase == pre && (c == CH_PLUS || c == CH_MINUS)) begin
         sign_neg = (c == CH_MINUS);
         phase    = pre + PHASE_W'(1);
      end else if (is_digit(c)) begin
         acc   = 16'(c - CH_ZERO);
         phase = pre + PHASE_W'(2);
      end else begin
         phase = PH_FAIL;
      end
   endtask

   task automatic feed_char(input logic [7:0] c);
      case (phase)
         PH_X:  phase = (c == CH_X) ? PH_C1 : PH_FAIL;
         PH_C1: phase = (c == CH_COLON) ? PH_XPRE : PH_FAIL;
         PH_XPRE, PH_XSGN: start_number(c, PH_XPRE, x_accum);
         PH_XDIG: begin
            if (is_digit(c)) begin
               x_accum = add_digit(x_accum, c);
            end else if (c == CH_COMMA) begin
               x_accum = signed_value(x_accum);
               phase   = PH_Y;
            end else begin
               phase = PH_FAIL;
            end
         end
         PH_Y:  phase = (c == CH_Y) ? PH_C2 : PH_FAIL;
         PH_C2: phase = (c == CH_COLON) ? PH_YPRE : PH_FAIL;
         PH_YPRE, PH_YSGN: start_number(c, PH_YPRE, y_accum);
         PH_YDIG: begin
            if (is_digit(c)) begin
               y_accum = add_digit(y_accum, c);
            end else begin
               y_accum = signed_value(y_accum);
               phase   = PH_MATCH;
            end
         end
         PH_MATCH: phase = PH_MATCH;
         default:  phase = PH_FAIL;
      endcase
   endtask

   task automatic predict_request(input logic func, input logic [7:0] ch);
      position_type res;
      res.updated = 1'b0;
      if (!func) begin
         if (ch == CH_LF) begin
            if (phase == PH_YDIG) begin
               y_accum = signed_value(y_accum);
               phase   = PH_MATCH;
            end
            if (phase == PH_MATCH) begin
               x_held      = x_accum;
               y_held      = y_accum;
               elapsed_ms  = '0;
               res.updated = 1'b1;
            end
            clear_line();
         end else if (ch != CH_CR && int'(line_count) < LINE_CHARS - 2) begin
            line_count = line_count + 8'd1;
            feed_char(ch);
         end
      end else if (elapsed_ms != ELAPSED_MAX) begin
         elapsed_ms = elapsed_ms + 16'd1;
      end
      res.timed_out = elapsed_ms > timeout_ms;
      if (res.timed_out) begin
         x_held = '0;
         y_held = '0;
      end
      res.x_pos = x_held;
      res.y_pos = y_held;
      expected_positions.push_back(res);
   endtask

   task automatic report_mismatch(input string field, input logic [15:0] want,
                                  input logic [15:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      position_type want;
      if (reset) begin
         expected_positions.delete();
         timeout_ms = TIMEOUT_RESET;
         clear_line();
         x_held     = '0;
         y_held     = '0;
         elapsed_ms = '0;
      end else begin
         // A response can never belong to a request accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_positions.size() == 0) begin
               $display("%0t: response with nothing expected, got %h / %h", $time,
                        rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_positions.pop_front();
               if (rsp_tdata[15:0] !== want.x_pos)
                  report_mismatch("x_pos", want.x_pos, rsp_tdata[15:0]);
               if (rsp_tdata[31:16] !== want.y_pos)
                  report_mismatch("y_pos", want.y_pos, rsp_tdata[31:16]);
               if (rsp_tuser[0] !== want.updated)
                  report_mismatch("updated", 16'(want.updated), 16'(rsp_tuser[0]));
               if (rsp_tuser[1] !== want.timed_out)
                  report_mismatch("timed_out", 16'(want.timed_out), 16'(rsp_tuser[1]));
            end
         end
         if (csr_valid && csr_ready) begin
            timeout_ms = csr_data;
         end
         if (req_tvalid && req_tready) begin
            predict_request(req_tuser, req_tdata);
         end
      end
      pending = expected_positions.size();
   end

endmodule

// ----- test/xy_position_line_parser_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the X/Y position line parser: clock, reset, stimulus and verdict.
// Depends on xypl_pkg, xy_position_line_parser and xy_position_line_parser_checker.
module xy_position_line_parser_tb;
   import xypl_pkg::*;

   localparam int LINE_CHARS   = 64;
   localparam int ITEM_TARGET  = 1050;
   localparam int PHASE_ITEMS  = 150;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TICK_RUN     = 40;

   typedef enum {LINE_GOOD, LINE_BROKEN, LINE_LONG_LEAD, LINE_LONG_TAIL} line_kind_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   int          fail_count;
   int          pending;
   int          sent;
   logic        idling;
   logic [7:0]  line_q[$];

   xy_position_line_parser #(
      .LINE_CHARS(LINE_CHARS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   xy_position_line_parser_checker #(
      .LINE_CHARS(LINE_CHARS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] random_blank();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_VT;
         default: return CH_FF;
      endcase
   endfunction

   // Any byte but LF, so that it stays inside the current line.
   function automatic logic [7:0] random_junk();
      logic [7:0] b;
      b = 8'($urandom);
      return (b == CH_LF) ? CH_SPACE : b;
   endfunction

   task automatic send_req(input logic func, input logic [7:0] ch);
      if (idling && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_req(1'b0, s[i]);
      end
   endtask

   // Holds back new requests until the checker has seen every response.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_number();
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
         line_q.push_back(random_blank());
      end
      if ($urandom_range(0, 1) == 1) begin
         line_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      end
      repeat ($urandom_range(1, 7)) begin
         line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
   endtask

   task automatic send_line(input line_kind_type kind);
      int pos;
      line_q.delete();
      line_q.push_back(CH_X);
      line_q.push_back(CH_COLON);
      // Enough leading blanks push the numbers past the examined part of the line.
      if (kind == LINE_LONG_LEAD) begin
         repeat ($urandom_range(40, 70)) line_q.push_back(random_blank());
      end
      add_number();
      line_q.push_back(CH_COMMA);
      line_q.push_back(CH_Y);
      line_q.push_back(CH_COLON);
      add_number();
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 4)) line_q.push_back(random_junk());
      end
      if (kind == LINE_LONG_TAIL) begin
         repeat ($urandom_range(40, 80)) line_q.push_back(random_junk());
      end
      if (kind == LINE_BROKEN) begin
         pos = $urandom_range(0, line_q.size() - 1);
         case ($urandom_range(0, 2))
            0:       line_q[pos] = random_junk();
            1:       line_q.insert(pos, random_blank());
            default: while (line_q.size() > pos) void'(line_q.pop_back());
         endcase
      end
      foreach (line_q[i]) begin
         if ($urandom_range(0, 11) == 0) send_req(1'b1, 8'($urandom));
         if ($urandom_range(0, 14) == 0) send_req(1'b0, CH_CR);
         send_req(1'b0, line_q[i]);
      end
      send_req(1'b0, CH_LF);
   endtask

   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run if no channel moves anything for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int random_start;
      int phase_start;
      int roll;
      logic [15:0] new_timeout;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      idling      = 1'b0;
      sent        = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // With a zero timeout a single tick after a good line clears the position.
      write_timeout(16'd0);
      send_text("X:\t-32768,Y:+99999Z");
      send_req(1'b0, CH_CR);
      send_req(1'b0, CH_LF);
      send_req(1'b1, 8'hFF);
      send_req(1'b0, 8'h00);
      send_req(1'b0, CH_LF);

      // A run of ticks under the largest timeout must not expire it.
      wait_for_results();
      write_timeout(16'hFFFF);
      send_text("X:7,Y:-7");
      send_req(1'b0, CH_LF);
      repeat (TICK_RUN) send_req(1'b1, 8'($urandom));
      wait_for_results();
      write_timeout(16'hFFFE);
      send_req(1'b1, 8'h00);

      random_start = sent;
      phase_start  = sent;
      idling       = 1'b1;
      while (sent - random_start < ITEM_TARGET) begin
         if (sent - phase_start >= PHASE_ITEMS) begin
            wait_for_results();
            case ($urandom_range(0, 4))
               0:       new_timeout = 16'd0;
               1:       new_timeout = 16'($urandom_range(1, 40));
               2:       new_timeout = 16'hFFFF;
               3:       new_timeout = TIMEOUT_RESET;
               default: new_timeout = 16'($urandom);
            endcase
            write_timeout(new_timeout);
            idling = (ITEM_TARGET - (sent - random_start) > 200) &&
                     ($urandom_range(0, 3) != 0);
            phase_start = sent;
         end
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            send_line(LINE_GOOD);
         end else if (roll < 70) begin
            send_line(LINE_BROKEN);
         end else if (roll < 76) begin
            send_line(LINE_LONG_LEAD);
         end else if (roll < 80) begin
            send_line(LINE_LONG_TAIL);
         end else if (roll < 90) begin
            repeat ($urandom_range(1, 40)) send_req(1'b1, 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 12)) send_req(1'($urandom), 8'($urandom));
            if ($urandom_range(0, 1) == 1) send_req(1'b0, CH_LF);
         end
      end

      wait_for_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
